### design/sfrm_pkg.sv
// ---------------------------------------------------------------------------
// sfrm_pkg: shared types and constants of the sample frame record marker
// Frame layout, item kinds, marker byte values and register map.
// ---------------------------------------------------------------------------
package sfrm_pkg;

    localparam int unsigned FRAME_BYTES = 6;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FRAME_W     = FRAME_BYTES * BYTE_W;
    localparam int unsigned COUNT_W     = 16;

    // 125 samples per second for 30 seconds
    localparam int unsigned SAMPLE_RATE_HZ = 125;
    localparam int unsigned RECORD_SECONDS = 30;
    localparam logic [COUNT_W-1:0] REC_LEN_RESET =
        COUNT_W'(SAMPLE_RATE_HZ * RECORD_SECONDS);

    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_FE   = 8'hFE;
    localparam logic [BYTE_W-1:0] BYTE_FF   = 8'hFF;

    // Register map: byte address 4*index, one register
    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0]  REG_RECORD_LENGTH = 1'b0;

    typedef logic [FRAME_BYTES-1:0][BYTE_W-1:0] frame_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_PRESS  = 1'b1
    } op_t;

    typedef struct packed {
        logic indicator;
        logic to_radio;
    } out_flags_t;

endpackage

### design/sfrm_marker.sv
// ---------------------------------------------------------------------------
// sfrm_marker: escape, recording state and start/end marking
// Combinational frame processing of one item plus the recording state,
// which advances when the item is taken.
// ---------------------------------------------------------------------------
module sfrm_marker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step,
    input  sfrm_pkg::op_t                      op,
    input  sfrm_pkg::frame_t                   frame_in,
    input  logic [sfrm_pkg::COUNT_W-1:0]       record_length,
    output sfrm_pkg::frame_t                   frame_out,
    output sfrm_pkg::out_flags_t               flags_out
);

    logic                         recording_reg, recording_next;
    logic [sfrm_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         lamp_reg, lamp_next;

    logic [sfrm_pkg::COUNT_W-1:0] count_inc;
    logic                         all_zero;
    logic                         all_ff;
    sfrm_pkg::frame_t             escaped;

    assign all_zero  = (frame_in == {sfrm_pkg::FRAME_BYTES{sfrm_pkg::BYTE_ZERO}});
    assign all_ff    = (frame_in == {sfrm_pkg::FRAME_BYTES{sfrm_pkg::BYTE_FF}});
    assign count_inc = count_reg + sfrm_pkg::COUNT_W'(1);

    always_comb begin
        escaped = frame_in;
        if (all_zero) begin
            escaped[2] = sfrm_pkg::BYTE_ONE;
            escaped[5] = sfrm_pkg::BYTE_ONE;
        end else if (all_ff) begin
            escaped[2] = sfrm_pkg::BYTE_FE;
            escaped[5] = sfrm_pkg::BYTE_FE;
        end
    end

    always_comb begin
        recording_next     = recording_reg;
        count_next         = count_reg;
        lamp_next          = lamp_reg;
        frame_out          = escaped;
        flags_out.to_radio = 1'b0;
        if (op == sfrm_pkg::OP_PRESS) begin
            recording_next = 1'b1;
        end else if (recording_reg) begin
            flags_out.to_radio = 1'b1;
            count_next         = count_inc;
            if (count_reg == '0) begin
                frame_out = {sfrm_pkg::FRAME_BYTES{sfrm_pkg::BYTE_FF}};
                lamp_next = ~lamp_next;
            end
            if (count_inc == record_length) begin
                frame_out      = {sfrm_pkg::FRAME_BYTES{sfrm_pkg::BYTE_ZERO}};
                lamp_next      = ~lamp_next;
                recording_next = 1'b0;
                count_next     = '0;
            end
        end
        flags_out.indicator = lamp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recording_reg <= 1'b0;
            count_reg     <= '0;
            lamp_reg      <= 1'b0;
        end else if (step) begin
            recording_reg <= recording_next;
            count_reg     <= count_next;
            lamp_reg      <= lamp_next;
        end
    end

endmodule

### design/sample_frame_record_marker_top.sv
// ---------------------------------------------------------------------------
// sample_frame_record_marker_top: sensor frame escaper and recording marker
// Escapes 6-byte sample frames and brackets recordings with start/end marks.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one transaction per item. s_tuser is the item kind
//   (0 = sample frame, 1 = start button press), s_tdata the six frame bytes.
//   Master stream (m_*): one transaction per sample frame; a press gives none.
//   m_tdata carries the escaped or marked frame, m_tuser the radio flag and
//   the indicator lamp level after the frame.
//   APB port: record_length at byte address 0 (bits 15:0). Write it only
//   while no transaction is in flight.
// Pipeline and throughput:
//   Two register stages (input register, result register): a sample frame
//   passes from the input register to the result register, which drives m_*.
//   One item per cycle is sustained while m_tready is high; the recording
//   counter and lamp update in the same cycle as the item leaves the input register.
// Reset: aresetn (synchronous, active low) empties both stages, stops any
//   recording, clears the sample counter and lamp, and sets record_length
//   to 3750.
// Stall: while m_tready is low a full result register holds; the input
//   register still takes a new item if it is empty, and a button press in it
//   retires without waiting for the master side.
// ---------------------------------------------------------------------------
module sample_frame_record_marker_top (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sfrm_pkg::FRAME_W-1:0]       s_tdata,   // in_byte_0 .. in_byte_5
    input  logic                               s_tuser,   // operation

    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sfrm_pkg::FRAME_W-1:0]       m_tdata,   // out_byte_0 .. out_byte_5
    output logic [1:0]                         m_tuser,   // to_radio, indicator

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sfrm_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // Configuration register
    logic [sfrm_pkg::COUNT_W-1:0] rec_len_reg;
    logic                         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[sfrm_pkg::PADDR_W-1] == sfrm_pkg::REG_RECORD_LENGTH);
    assign prdata  = reg_sel ? {16'd0, rec_len_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_len_reg <= sfrm_pkg::REC_LEN_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            rec_len_reg <= pwdata[sfrm_pkg::COUNT_W-1:0];
        end
    end

    // Input register stage
    logic             in_valid_reg;
    sfrm_pkg::op_t    in_op_reg;
    sfrm_pkg::frame_t in_frame_reg;
    logic             advance;
    logic             out_load;

    // Retire the held item: a press needs no room, a sample needs the result
    // register free or draining this cycle.
    assign advance  = in_valid_reg &&
                      ((in_op_reg == sfrm_pkg::OP_PRESS) || !m_tvalid || m_tready);
    assign out_load = advance && (in_op_reg == sfrm_pkg::OP_SAMPLE);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= sfrm_pkg::op_t'(s_tuser);
            in_frame_reg <= sfrm_pkg::frame_t'(s_tdata);
        end
    end

    // Marking logic and recording state
    sfrm_pkg::frame_t     frame_res;
    sfrm_pkg::out_flags_t flags_res;

    sfrm_marker u_marker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .op            (in_op_reg),
        .frame_in      (in_frame_reg),
        .record_length (rec_len_reg),
        .frame_out     (frame_res),
        .flags_out     (flags_res)
    );

    // Result register stage
    logic                 out_valid_reg;
    sfrm_pkg::frame_t     out_frame_reg;
    sfrm_pkg::out_flags_t out_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_frame_reg <= frame_res;
            out_flags_reg <= flags_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_frame_reg;
    assign m_tuser  = {out_flags_reg.indicator, out_flags_reg.to_radio};

endmodule
